// File: design/link_reconnect_supervisor_top_defines.svh
// Assertion macros for the link reconnect supervisor.
`ifndef LINK_RECONNECT_SUPERVISOR_TOP_DEFINES_SVH
`define LINK_RECONNECT_SUPERVISOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Property that holds at every clock edge outside reset.
`define LRS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: %m");
// Property whose consequent holds in the cycle after its antecedent.
`define LRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: %m");
`else
`define LRS_ASSERT(label, clk, rst, prop)
`define LRS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: design/lrs_pkg.sv
package lrs_pkg;

   localparam int OPCODE_W   = 3;
   localparam int MODE_W     = 3;
   localparam int ATTEMPTS_W = 9;
   localparam int MAX_ATT_W  = 8;
   localparam int DELAY_W    = 20;
   localparam int ELAPSED_W  = 21;
   localparam int CSR_ADDR_W = 2;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 24;

   localparam logic [ATTEMPTS_W-1:0] ATTEMPTS_SAT = ATTEMPTS_W'(256);
   localparam logic [ELAPSED_W-1:0]  ELAPSED_SAT  = {ELAPSED_W{1'b1}};

   localparam logic [MAX_ATT_W-1:0] MAX_ATTEMPTS_RST    = MAX_ATT_W'(5);
   localparam logic [DELAY_W-1:0]   INITIAL_DELAY_RST   = DELAY_W'(1000);
   localparam logic [DELAY_W-1:0]   MAX_DELAY_RST       = DELAY_W'(32000);
   localparam logic [DELAY_W-1:0]   CONNECT_TIMEOUT_RST = DELAY_W'(10000);

   typedef enum logic [MODE_W-1:0] {
      MODE_IDLE         = 3'd0,
      MODE_CONNECTING   = 3'd1,
      MODE_CONNECTED    = 3'd2,
      MODE_RECONNECTING = 3'd3,
      MODE_FALLBACK     = 3'd4,
      MODE_DISCONNECTED = 3'd5
   } mode_type;

   typedef enum logic [OPCODE_W-1:0] {
      OP_TICK        = 3'd0,
      OP_CONNECT     = 3'd1,
      OP_DISCONNECT  = 3'd2,
      OP_RECONNECT   = 3'd3,
      OP_GOT_ADDRESS = 3'd4,
      OP_LINK_LOST   = 3'd5
   } op_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_MAX_ATTEMPTS    = 2'd0,
      CSR_INITIAL_DELAY   = 2'd1,
      CSR_MAX_DELAY       = 2'd2,
      CSR_CONNECT_TIMEOUT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [MAX_ATT_W-1:0] max_attempts;
      logic [DELAY_W-1:0]   initial_delay;
      logic [DELAY_W-1:0]   max_delay;
      logic [DELAY_W-1:0]   connect_timeout;
   } cfg_type;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic                link_up;
      logic                candidate_found;
   } item_type;

   typedef struct packed {
      logic                  fallback_event;
      logic                  retry_event;
      logic                  lost_event;
      logic                  connected_event;
      logic                  start_connect;
      logic [ATTEMPTS_W-1:0] attempt_count;
      logic [MODE_W-1:0]     mode;
   } result_type;

endpackage

// File: design/lrs_csr.sv
module lrs_csr
   import lrs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [DELAY_W-1:0]    csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_MAX_ATTEMPTS:    cfg_in.max_attempts    = csr_wdata[MAX_ATT_W-1:0];
            CSR_INITIAL_DELAY:   cfg_in.initial_delay   = csr_wdata;
            CSR_MAX_DELAY:       cfg_in.max_delay       = csr_wdata;
            CSR_CONNECT_TIMEOUT: cfg_in.connect_timeout = csr_wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_attempts    <= MAX_ATTEMPTS_RST;
         cfg_ff.initial_delay   <= INITIAL_DELAY_RST;
         cfg_ff.max_delay       <= MAX_DELAY_RST;
         cfg_ff.connect_timeout <= CONNECT_TIMEOUT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: design/lrs_in_stage.sv
module lrs_in_stage
   import lrs_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   input  logic     drain,
   output logic     item_valid,
   output item_type item
);

   logic     valid_ff;
   item_type item_ff;

   // Take a new item when empty or when the held one moves on this cycle.
   assign in_ready = !valid_ff || drain;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= in_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// File: design/lrs_engine.sv
module lrs_engine
   import lrs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  fire,
   input  item_type              item,
   output result_type            result,
   output logic [ATTEMPTS_W-1:0] attempts
);

   mode_type               mode_ff, mode_in;
   logic [ATTEMPTS_W-1:0]  attempts_ff, attempts_in;
   logic [DELAY_W-1:0]     delay_ff, delay_in;
   logic [ELAPSED_W-1:0]   conn_el_ff, conn_el_in;
   logic [ELAPSED_W-1:0]   back_el_ff, back_el_in;

   logic [ELAPSED_W-1:0]   conn_el_inc;
   logic [ELAPSED_W-1:0]   back_el_inc;
   logic [ATTEMPTS_W-1:0]  attempts_inc;
   logic [DELAY_W:0]       delay_dbl;
   logic [DELAY_W-1:0]     delay_next;

   assign conn_el_inc  = (conn_el_ff == ELAPSED_SAT) ? ELAPSED_SAT : conn_el_ff + 1'b1;
   assign back_el_inc  = (back_el_ff == ELAPSED_SAT) ? ELAPSED_SAT : back_el_ff + 1'b1;
   assign attempts_inc = (attempts_ff >= ATTEMPTS_SAT) ? ATTEMPTS_SAT
                                                       : attempts_ff + 1'b1;
   assign delay_dbl    = {delay_ff, 1'b0};
   assign delay_next   = (delay_dbl < {1'b0, cfg.max_delay}) ? delay_dbl[DELAY_W-1:0]
                                                             : cfg.max_delay;

   always_comb begin
      mode_in     = mode_ff;
      attempts_in = attempts_ff;
      delay_in    = delay_ff;
      conn_el_in  = conn_el_ff;
      back_el_in  = back_el_ff;
      result      = '0;

      case (item.opcode)
         OP_TICK: begin
            conn_el_in = conn_el_inc;
            back_el_in = back_el_inc;
            case (mode_ff)
               MODE_CONNECTING: begin
                  if (item.link_up) begin
                     mode_in                = MODE_CONNECTED;
                     attempts_in            = '0;
                     delay_in               = cfg.initial_delay;
                     result.connected_event = 1'b1;
                  end else if (conn_el_inc > {1'b0, cfg.connect_timeout}) begin
                     mode_in = MODE_RECONNECTING;
                  end
               end
               MODE_CONNECTED: begin
                  if (!item.link_up) begin
                     mode_in           = MODE_RECONNECTING;
                     result.lost_event = 1'b1;
                  end
               end
               MODE_RECONNECTING: begin
                  if (back_el_inc >= {1'b0, delay_ff}) begin
                     attempts_in = attempts_inc;
                     if (attempts_inc > {1'b0, cfg.max_attempts}) begin
                        mode_in               = MODE_FALLBACK;
                        result.fallback_event = 1'b1;
                     end else begin
                        result.retry_event = 1'b1;
                        if (item.candidate_found) begin
                           mode_in              = MODE_CONNECTING;
                           conn_el_in           = '0;
                           result.start_connect = 1'b1;
                        end
                        back_el_in = '0;
                        delay_in   = delay_next;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         OP_CONNECT: begin
            mode_in              = MODE_CONNECTING;
            conn_el_in           = '0;
            result.start_connect = 1'b1;
         end
         OP_DISCONNECT: begin
            mode_in = MODE_DISCONNECTED;
         end
         OP_RECONNECT: begin
            attempts_in = '0;
            back_el_in  = '0;
            mode_in     = MODE_RECONNECTING;
         end
         OP_GOT_ADDRESS: begin
            mode_in                = MODE_CONNECTED;
            result.connected_event = 1'b1;
         end
         OP_LINK_LOST: begin
            if (mode_ff == MODE_CONNECTED) begin
               mode_in           = MODE_RECONNECTING;
               result.lost_event = 1'b1;
            end
         end
         default: begin
         end
      endcase

      result.mode          = mode_in;
      result.attempt_count = attempts_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_IDLE;
         attempts_ff <= '0;
         delay_ff    <= INITIAL_DELAY_RST;
         conn_el_ff  <= '0;
         back_el_ff  <= '0;
      end else if (fire) begin
         mode_ff     <= mode_in;
         attempts_ff <= attempts_in;
         delay_ff    <= delay_in;
         conn_el_ff  <= conn_el_in;
         back_el_ff  <= back_el_in;
      end
   end

   assign attempts = attempts_ff;

endmodule

// File: design/lrs_out_stage.sv
module lrs_out_stage
   import lrs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type result,
   output logic       out_ready,
   output logic       out_valid,
   input  logic       out_taken,
   output result_type out_result
);

   logic       valid_ff;
   result_type result_ff;

   // Free when empty or when the held result transfers this cycle.
   assign out_ready = !valid_ff || out_taken;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (out_ready) begin
         valid_ff <= load;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && load) begin
         result_ff <= result;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

// File: design/link_reconnect_supervisor_top.sv
// Link reconnect supervisor with exponential backoff. Each request is a
// 1 ms tick, a command or a link event; each produces exactly one response
// holding the new mode, the attempt count and the event pulses. One request
// is taken every clock cycle while the response side is not stalled; a
// request that transfers passes through the input register, then the
// mode/counter update into the response register; the single update stage
// that owns the mode and counter registers sets that rate. After reset the
// registers hold max_attempts 5, initial_delay 1000, max_delay 32000 and
// connect_timeout 10000; write them over the csr port only while no request is in flight.
`include "link_reconnect_supervisor_top_defines.svh"

module link_reconnect_supervisor_top
   import lrs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [DELAY_W-1:0]    csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [0] link_up, [1] candidate_found, [7:2] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [2:0] opcode
   input  logic [OPCODE_W-1:0]   req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [2:0] mode, [11:3] attempt_count, [12] start_connect,
   // [13] connected_event, [14] lost_event, [15] retry_event,
   // [16] fallback_event, [23:17] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   cfg_type               cfg;
   item_type              req_item;
   item_type              item;
   logic                  item_valid;
   logic                  out_ready;
   logic                  fire;
   result_type            result;
   result_type            rsp_result;
   logic [ATTEMPTS_W-1:0] attempts;
   logic [3:0]            rsp_events;
   logic                  rsp_start;
   logic                  rsp_fallback;

   assign req_item.opcode          = req_tuser;
   assign req_item.link_up         = req_tdata[0];
   assign req_item.candidate_found = req_tdata[1];

   assign fire = item_valid && out_ready;

   lrs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lrs_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (req_item),
      .drain      (out_ready),
      .item_valid (item_valid),
      .item       (item)
   );

   lrs_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .fire     (fire),
      .item     (item),
      .result   (result),
      .attempts (attempts)
   );

   lrs_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (fire),
      .result     (result),
      .out_ready  (out_ready),
      .out_valid  (rsp_tvalid),
      .out_taken  (rsp_tready),
      .out_result (rsp_result)
   );

   assign rsp_tdata = {(RSP_DATA_W - $bits(result_type))'(0), rsp_result};

   assign rsp_events   = {rsp_result.connected_event, rsp_result.lost_event,
                          rsp_result.retry_event, rsp_result.fallback_event};
   assign rsp_start    = rsp_tvalid && rsp_result.start_connect;
   assign rsp_fallback = rsp_tvalid && rsp_result.fallback_event;

   `LRS_ASSERT(a_one_event, clock, reset, !rsp_tvalid || $onehot0(rsp_events))
   `LRS_ASSERT(a_start_mode, clock, reset, !rsp_start || (rsp_result.mode == MODE_CONNECTING))
   `LRS_ASSERT(a_fallback_mode, clock, reset, !rsp_fallback || (rsp_result.mode == MODE_FALLBACK))
   `LRS_ASSERT(a_attempts_cap, clock, reset, attempts <= ATTEMPTS_SAT)
   `LRS_ASSERT_NEXT(a_item_hold, clock, reset, item_valid && !out_ready, item_valid)

endmodule

// File: test/link_reconnect_supervisor_top_test.sv
module link_reconnect_supervisor_top_test;
   import lrs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [OPCODE_W-1:0] OP_SPARE_7 = 3'd7;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES     = 10;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [DELAY_W-1:0]    csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [OPCODE_W-1:0]   req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // Expected supervisor state and register copy
   cfg_type               cfg;
   mode_type              sup_mode;
   logic [ATTEMPTS_W-1:0] sup_attempts;
   logic [DELAY_W-1:0]    sup_delay;
   logic [ELAPSED_W-1:0]  sup_conn_ms;
   logic [ELAPSED_W-1:0]  sup_backoff_ms;

   result_type pending_results[$];
   int         mismatch_count = 0;
   int         send_idle_pct = 0;
   int         rsp_stall_pct = 0;
   logic       hold_toggle = 1'b0;
   logic       hold_seen = 1'b0;
   int         hold_left = 0;

   link_reconnect_supervisor_top u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   function automatic result_type supervisor_next(logic [OPCODE_W-1:0] op, logic link_up,
                                                  logic cand);
      result_type        res;
      logic [DELAY_W:0]  doubled;
      res = '0;
      case (op)
         OP_TICK: begin
            if (sup_conn_ms != ELAPSED_SAT) sup_conn_ms++;
            if (sup_backoff_ms != ELAPSED_SAT) sup_backoff_ms++;
            case (sup_mode)
               MODE_CONNECTING: begin
                  if (link_up) begin
                     sup_mode = MODE_CONNECTED;
                     sup_attempts = '0;
                     sup_delay = cfg.initial_delay;
                     res.connected_event = 1'b1;
                  end else if (sup_conn_ms > {1'b0, cfg.connect_timeout}) begin
                     sup_mode = MODE_RECONNECTING;
                  end
               end
               MODE_CONNECTED: begin
                  if (!link_up) begin
                     sup_mode = MODE_RECONNECTING;
                     res.lost_event = 1'b1;
                  end
               end
               MODE_RECONNECTING: begin
                  if (sup_backoff_ms >= {1'b0, sup_delay}) begin
                     if (sup_attempts != ATTEMPTS_SAT) sup_attempts++;
                     if (sup_attempts > {1'b0, cfg.max_attempts}) begin
                        sup_mode = MODE_FALLBACK;
                        res.fallback_event = 1'b1;
                     end else begin
                        doubled = {sup_delay, 1'b0};
                        res.retry_event = 1'b1;
                        if (cand) begin
                           sup_mode = MODE_CONNECTING;
                           sup_conn_ms = '0;
                           res.start_connect = 1'b1;
                        end
                        sup_backoff_ms = '0;
                        // cap the doubled delay at max_delay
                        if (doubled < {1'b0, cfg.max_delay}) begin
                           sup_delay = doubled[DELAY_W-1:0];
                        end else begin
                           sup_delay = cfg.max_delay;
                        end
                     end
                  end
               end
               default: ;
            endcase
         end
         OP_CONNECT: begin
            sup_mode = MODE_CONNECTING;
            sup_conn_ms = '0;
            res.start_connect = 1'b1;
         end
         OP_DISCONNECT: sup_mode = MODE_DISCONNECTED;
         OP_RECONNECT: begin
            sup_attempts = '0;
            sup_backoff_ms = '0;
            sup_mode = MODE_RECONNECTING;
         end
         OP_GOT_ADDRESS: begin
            sup_mode = MODE_CONNECTED;
            res.connected_event = 1'b1;
         end
         OP_LINK_LOST: begin
            if (sup_mode == MODE_CONNECTED) begin
               sup_mode = MODE_RECONNECTING;
               res.lost_event = 1'b1;
            end
         end
         default: ;
      endcase
      res.mode = sup_mode;
      res.attempt_count = sup_attempts;
      return res;
   endfunction

   // Offer one event, wait for its transfer, then queue its expected response.
   task automatic send_event(logic [OPCODE_W-1:0] op, logic link_up, logic cand);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {6'b0, cand, link_up};
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      pending_results.insert(pending_results.size(), supervisor_next(op, link_up, cand));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic load_config(logic [MAX_ATT_W-1:0] max_att, logic [DELAY_W-1:0] init_ms,
                              logic [DELAY_W-1:0] max_ms, logic [DELAY_W-1:0] timeout_ms);
      wait_drained();
      csr_we <= 1'b1;
      csr_addr <= CSR_MAX_ATTEMPTS;
      csr_wdata <= DELAY_W'(max_att);
      @(posedge clock);
      csr_addr <= CSR_INITIAL_DELAY;
      csr_wdata <= init_ms;
      @(posedge clock);
      csr_addr <= CSR_MAX_DELAY;
      csr_wdata <= max_ms;
      @(posedge clock);
      csr_addr <= CSR_CONNECT_TIMEOUT;
      csr_wdata <= timeout_ms;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg.max_attempts = max_att;
      cfg.initial_delay = init_ms;
      cfg.max_delay = max_ms;
      cfg.connect_timeout = timeout_ms;
   endtask

   task automatic compare_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // Sample the response handshake mid-cycle; the transfer lands on the next rising edge.
   always @(negedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = result_type'(rsp_tdata[$bits(result_type)-1:0]);
         if (pending_results.size() == 0) begin
            $error("response transfer with no request pending: %h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            compare_field("mode", int'(want.mode), int'(got.mode));
            compare_field("attempt_count", int'(want.attempt_count),
                          int'(got.attempt_count));
            compare_field("start_connect", int'(want.start_connect),
                          int'(got.start_connect));
            compare_field("connected_event", int'(want.connected_event),
                          int'(got.connected_event));
            compare_field("lost_event", int'(want.lost_event), int'(got.lost_event));
            compare_field("retry_event", int'(want.retry_event), int'(got.retry_event));
            compare_field("fallback_event", int'(want.fallback_event),
                          int'(got.fallback_event));
         end
      end
   end

   // Response side: random stalls, plus a long hold-off on request.
   always @(posedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen <= hold_toggle;
         hold_left <= LONG_HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic test_reset_defaults();
      send_event(OP_TICK, 1'b0, 1'b0);
      send_event(OP_SPARE_6, 1'b0, 1'b0);
      send_event(OP_SPARE_7, 1'b1, 1'b1);
      send_event(OP_LINK_LOST, 1'b1, 1'b0);
      send_event(OP_CONNECT, 1'b0, 1'b1);
      send_event(OP_TICK, 1'b0, 1'b1);
      send_event(OP_GOT_ADDRESS, 1'b0, 1'b0);
      send_event(OP_LINK_LOST, 1'b0, 1'b0);
      send_event(OP_TICK, 1'b1, 1'b1);
      send_event(OP_DISCONNECT, 1'b1, 1'b0);
      send_event(OP_RECONNECT, 1'b0, 1'b0);
      send_event(OP_TICK, 1'b0, 1'b1);
   endtask

   task automatic test_retry_sequence();
      load_config(8'd2, 20'd2, 20'd3, 20'd1);
      send_event(OP_CONNECT, 1'b0, 1'b0);
      send_event(OP_TICK, 1'b0, 1'b0);
      send_event(OP_TICK, 1'b0, 1'b0);
      send_event(OP_TICK, 1'b0, 1'b1);
      send_event(OP_TICK, 1'b0, 1'b1);
      send_event(OP_TICK, 1'b1, 1'b0);
      send_event(OP_TICK, 1'b1, 1'b1);
      send_event(OP_TICK, 1'b0, 1'b0);
      send_event(OP_LINK_LOST, 1'b0, 1'b0);
      send_event(OP_GOT_ADDRESS, 1'b0, 1'b0);
      send_event(OP_LINK_LOST, 1'b1, 1'b1);
      repeat (10) send_event(OP_TICK, 1'b0, 1'b0);
      send_event(OP_RECONNECT, 1'b1, 1'b1);
      send_event(OP_DISCONNECT, 1'b0, 1'b0);
      send_event(OP_TICK, 1'b1, 1'b1);
      // zero attempts allowed and zero delays: first retry falls back at once
      load_config(8'd0, 20'd0, 20'd0, 20'd0);
      send_event(OP_RECONNECT, 1'b0, 1'b0);
      send_event(OP_TICK, 1'b0, 1'b1);
      send_event(OP_CONNECT, 1'b0, 1'b0);
      send_event(OP_TICK, 1'b0, 1'b0);
   endtask

   task automatic test_attempt_saturation();
      load_config(8'd255, 20'd0, 20'd0, 20'd0);
      send_event(OP_RECONNECT, 1'b0, 1'b0);
      repeat (ATTEMPTS_SAT) send_event(OP_TICK, 1'b0, 1'b0);
      send_event(OP_GOT_ADDRESS, 1'b0, 1'b0);
      send_event(OP_LINK_LOST, 1'b0, 1'b0);
      send_event(OP_TICK, 1'b0, 1'b1);
      send_event(OP_RECONNECT, 1'b0, 1'b0);
   endtask

   task automatic test_backpressure();
      load_config(8'd3, 20'd1, 20'd4, 20'd2);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_toggle <= ~hold_toggle;
      repeat (40) send_event(OP_TICK, 1'($urandom), 1'($urandom));
      // hold the sender until every response is back
      wait_drained();
      repeat (20) send_event(OP_TICK, 1'($urandom), 1'($urandom));
   endtask

   task automatic run_random_phase(int count, int idle_pct, int stall_pct);
      int               pick;
      logic [OPCODE_W-1:0] op;
      logic             link_up;
      logic             cand;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (count) begin
         pick = $urandom_range(99);
         link_up = 1'($urandom);
         cand = ($urandom_range(99) < 60);
         if (pick < 10) begin
            op = OPCODE_W'($urandom_range(7));
         end else if (pick < 72) begin
            op = OP_TICK;
            // keep a live link up, let attempts mostly time out
            if (sup_mode == MODE_CONNECTED) begin
               link_up = ($urandom_range(99) < 92);
            end else if (sup_mode == MODE_CONNECTING) begin
               link_up = ($urandom_range(99) < 20);
            end
         end else if (pick < 80) begin
            op = OP_CONNECT;
         end else if (pick < 86) begin
            op = OP_GOT_ADDRESS;
         end else if (pick < 92) begin
            op = OP_LINK_LOST;
         end else if (pick < 97) begin
            op = OP_RECONNECT;
         end else begin
            op = OP_DISCONNECT;
         end
         send_event(op, link_up, cand);
      end
   endtask

   task automatic test_random_traffic();
      load_config(8'd3, 20'd1, 20'd6, 20'd3);
      run_random_phase(110, 0, 0);
      load_config(8'd0, 20'd0, 20'd0, 20'd0);
      run_random_phase(110, 57, 0);
      load_config(8'd255, 20'd1, 20'hFFFFF, 20'd5);
      run_random_phase(110, 0, 57);
      load_config(8'd4, 20'd2, 20'd5, 20'd1);
      run_random_phase(110, 24, 24);
   endtask

   initial begin
      cfg.max_attempts = MAX_ATTEMPTS_RST;
      cfg.initial_delay = INITIAL_DELAY_RST;
      cfg.max_delay = MAX_DELAY_RST;
      cfg.connect_timeout = CONNECT_TIMEOUT_RST;
      sup_mode = MODE_IDLE;
      sup_attempts = '0;
      sup_delay = INITIAL_DELAY_RST;
      sup_conn_ms = '0;
      sup_backoff_ms = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_retry_sequence();
      test_attempt_saturation();
      test_backpressure();
      test_random_traffic();

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #100_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
